// ===== design/rmat_pkg.sv =====
// ----------------------------------------------------------------------------
// rmat_pkg
// Shared types and constants for the reference-counted MAC address table.
// ----------------------------------------------------------------------------
package rmat_pkg;

	localparam int MAX_ENTRIES_DEF = 32;
	localparam int ADDR_W          = 48;
	localparam int REF_W           = 16;
	localparam int FLAG_W          = 16;
	localparam int CNT_OUT_W       = 6;

	localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};
	localparam logic [REF_W-1:0] REF_ONE = REF_W'(1);

	// request operation codes
	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_DEL   = 2'd1,
		FUNC_FLUSH = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOROOM   = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	// control states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE
	} state_t;

	// one table entry as held in the slot memory
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [REF_W-1:0]  refcnt;
		logic [FLAG_W-1:0] flags;
	} entry_t;

endpackage

// ===== design/refcounted_mac_address_table.sv =====
// ----------------------------------------------------------------------------
// refcounted_mac_address_table
// Table of MAC addresses with reference counts and flag words.
//
// Request channel (req_valid / req_stall) carries func, mac_addr, flag_bits:
// add, delete or flush. Response channel (rsp_valid / rsp_stall) returns one
// result per request: status, entry_count, ref_after, flags_after, entry_freed.
// Entries live in one slot memory with a registered read; valid
// bits and the entry count are flip-flops.
// Each request walks the slots in order, one memory read per cycle. Add and
// delete stop at the first matching slot; flush, the unused code and misses
// walk all slots. rsp_valid rises from the response register, which S_UPDATE
// loads once the walk has ended. One request is in service at a time;
// req_stall is high while it is and falls in the same cycle as rsp_valid rises.
// The response sits in an output register, so the next request is accepted
// while an earlier response is still stalled; a finished walk waits for the
// output register to free up before writing back.
// Reset clears all valid bits and the count at once; no clearing pass.
// ----------------------------------------------------------------------------
module refcounted_mac_address_table #(
	parameter int MAX_ENTRIES = rmat_pkg::MAX_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    func,
	input  logic [rmat_pkg::ADDR_W-1:0]   mac_addr,
	input  logic [rmat_pkg::FLAG_W-1:0]   flag_bits,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [1:0]                    status,
	output logic [rmat_pkg::CNT_OUT_W-1:0] entry_count,
	output logic [rmat_pkg::REF_W-1:0]    ref_after,
	output logic [rmat_pkg::FLAG_W-1:0]   flags_after,
	output logic                          entry_freed
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

	// slot memory
	rmat_pkg::entry_t mem [MAX_ENTRIES];

	rmat_pkg::state_t state_q, state_d;

	// captured request
	rmat_pkg::func_t               func_q;
	logic [rmat_pkg::ADDR_W-1:0]   mac_q;
	logic [rmat_pkg::FLAG_W-1:0]   fl_q;

	// walk control
	logic                 issue_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	rmat_pkg::entry_t     rd_data_s1;

	// walk results
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	rmat_pkg::entry_t     hit_ent_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic                 freed_q;

	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]       count_q, count_d;

	// response register
	logic                         rsp_valid_q;
	rmat_pkg::status_t            status_q;
	logic [rmat_pkg::CNT_OUT_W-1:0] entry_count_q;
	logic [rmat_pkg::REF_W-1:0]   ref_after_q;
	logic [rmat_pkg::FLAG_W-1:0]  flags_after_q;
	logic                         entry_freed_q;

	// combinational controls
	logic                 req_acc;
	logic                 s1_act, s1_vbit, s1_match, s1_last, is_lookup;
	logic                 upd_fire;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_wa;
	rmat_pkg::entry_t     mem_wd;
	logic                 vset_en, vclr_en;
	logic [IDX_W-1:0]     vset_idx, vclr_idx;
	logic                 flush_free;
	rmat_pkg::status_t    res_status;
	logic [rmat_pkg::REF_W-1:0]  res_ref;
	logic [rmat_pkg::FLAG_W-1:0] res_flags;
	logic                 res_freed;
	logic [CNT_W+rmat_pkg::CNT_OUT_W-1:0] cnt_wide;

	assign req_stall = (state_q != rmat_pkg::S_IDLE);
	assign req_acc   = req_valid && !req_stall;

	// scan stage: data for slot idx_s1 is present
	assign is_lookup = (func_q == rmat_pkg::FUNC_ADD) || (func_q == rmat_pkg::FUNC_DEL);
	assign s1_act    = (state_q == rmat_pkg::S_SCAN) && rd_vld_s1;
	assign s1_vbit   = valid_q[idx_s1];
	assign s1_match  = s1_act && is_lookup && s1_vbit && (rd_data_s1.addr == mac_q);
	assign s1_last   = s1_act && (idx_s1 == LAST_IDX);
	assign upd_fire  = (state_q == rmat_pkg::S_UPDATE) && (!rsp_valid_q || !rsp_stall);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, write-back and result
	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_wa     = idx_s1;
		mem_wd     = rd_data_s1;
		vset_en    = 1'b0;
		vset_idx   = free_idx_q;
		vclr_en    = 1'b0;
		vclr_idx   = idx_s1;
		flush_free = 1'b0;
		count_d    = count_q;
		res_status = rmat_pkg::ST_OK;
		res_ref    = '0;
		res_flags  = '0;
		res_freed  = 1'b0;
		case (state_q)
			rmat_pkg::S_IDLE: begin
				if (req_acc) begin
					state_d = rmat_pkg::S_SCAN;
				end
			end
			rmat_pkg::S_SCAN: begin
				// flush decrements each valid slot as the walk passes it
				if (s1_act && (func_q == rmat_pkg::FUNC_FLUSH) && s1_vbit) begin
					if (rd_data_s1.refcnt <= rmat_pkg::REF_ONE) begin
						flush_free = 1'b1;
						vclr_en    = 1'b1;
						vclr_idx   = idx_s1;
						if (count_q != '0) begin
							count_d = count_q - CNT_W'(1);
						end
					end else begin
						mem_we        = 1'b1;
						mem_wa        = idx_s1;
						mem_wd        = rd_data_s1;
						mem_wd.refcnt = rd_data_s1.refcnt - rmat_pkg::REF_ONE;
					end
				end
				if (s1_match || s1_last) begin
					state_d = rmat_pkg::S_UPDATE;
				end
			end
			rmat_pkg::S_UPDATE: begin
				res_freed = freed_q;
				if (func_q == rmat_pkg::FUNC_ADD) begin
					if (hit_q) begin
						mem_wd = hit_ent_q;
						if (hit_ent_q.refcnt != rmat_pkg::REF_MAX) begin
							mem_wd.refcnt = hit_ent_q.refcnt + rmat_pkg::REF_ONE;
						end
						mem_wd.flags = hit_ent_q.flags | fl_q;
						mem_wa       = hit_idx_q;
						mem_we       = upd_fire;
						res_ref      = mem_wd.refcnt;
						res_flags    = mem_wd.flags;
					end else if (free_found_q) begin
						mem_wd.addr   = mac_q;
						mem_wd.refcnt = rmat_pkg::REF_ONE;
						mem_wd.flags  = fl_q;
						mem_wa        = free_idx_q;
						mem_we        = upd_fire;
						vset_en       = upd_fire;
						vset_idx      = free_idx_q;
						count_d       = upd_fire ? count_q + CNT_W'(1) : count_q;
						res_ref       = rmat_pkg::REF_ONE;
						res_flags     = fl_q;
					end else begin
						res_status = rmat_pkg::ST_NOROOM;
					end
				end else if (func_q == rmat_pkg::FUNC_DEL) begin
					if (!hit_q) begin
						res_status = rmat_pkg::ST_NOTFOUND;
					end else if (hit_ent_q.refcnt <= rmat_pkg::REF_ONE) begin
						vclr_en   = upd_fire;
						vclr_idx  = hit_idx_q;
						res_freed = 1'b1;
						if (upd_fire && (count_q != '0)) begin
							count_d = count_q - CNT_W'(1);
						end
					end else begin
						mem_wd        = hit_ent_q;
						mem_wd.refcnt = hit_ent_q.refcnt - rmat_pkg::REF_ONE;
						mem_wd.flags  = hit_ent_q.flags & ~fl_q;
						mem_wa        = hit_idx_q;
						mem_we        = upd_fire;
						res_ref       = mem_wd.refcnt;
						res_flags     = mem_wd.flags;
					end
				end
				if (upd_fire) begin
					state_d = rmat_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rmat_pkg::S_IDLE;
			end
		endcase
	end

	assign cnt_wide = (CNT_W + rmat_pkg::CNT_OUT_W)'(count_d);

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem[rd_idx_q];
	end

	// request capture and walk bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q      <= 1'b0;
			rd_idx_q     <= '0;
			rd_vld_s1    <= 1'b0;
			idx_s1       <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			freed_q      <= 1'b0;
			valid_q      <= '0;
			count_q      <= '0;
		end else begin
			rd_vld_s1 <= (state_q == rmat_pkg::S_SCAN) && issue_q && !s1_match;
			idx_s1    <= rd_idx_q;
			count_q   <= count_d;
			if (req_acc) begin
				issue_q      <= 1'b1;
				rd_idx_q     <= '0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
				freed_q      <= 1'b0;
			end else if (state_q == rmat_pkg::S_SCAN) begin
				// read index stops at the last slot
				if (issue_q) begin
					if (rd_idx_q == LAST_IDX) begin
						issue_q <= 1'b0;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				if (s1_match) begin
					issue_q <= 1'b0;
					hit_q   <= 1'b1;
				end
				if (s1_act && !s1_vbit && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				if (flush_free) begin
					freed_q <= 1'b1;
				end
			end
			if (vset_en) begin
				valid_q[vset_idx] <= 1'b1;
			end
			if (vclr_en) begin
				valid_q[vclr_idx] <= 1'b0;
			end
		end
	end

	// payload captures
	always_ff @(posedge clk) begin
		if (req_acc) begin
			func_q <= rmat_pkg::func_t'(func);
			mac_q  <= mac_addr;
			fl_q   <= flag_bits;
		end
		if (s1_match) begin
			hit_idx_q <= idx_s1;
			hit_ent_q <= rd_data_s1;
		end
		if (s1_act && !s1_vbit && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (upd_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			status_q      <= res_status;
			entry_count_q <= cnt_wide[rmat_pkg::CNT_OUT_W-1:0];
			ref_after_q   <= res_ref;
			flags_after_q <= res_flags;
			entry_freed_q <= res_freed;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign ref_after   = ref_after_q;
	assign flags_after = flags_after_q;
	assign entry_freed = entry_freed_q;

	// checks
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmat_pkg::S_IDLE) |-> (count_q == CNT_W'($countones(valid_q))))
		else $error("entry count disagrees with valid bits");

	a_rsp_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == rmat_pkg::S_UPDATE))
		else $error("response loaded outside update state");

	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == rmat_pkg::S_UPDATE) && hit_q) |-> valid_q[hit_idx_q])
		else $error("matched slot is not valid");

	a_free_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == rmat_pkg::S_UPDATE) && free_found_q && !hit_q &&
		 (func_q == rmat_pkg::FUNC_ADD)) |-> !valid_q[free_idx_q])
		else $error("chosen free slot is occupied");

	a_err_zero_ref: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q != rmat_pkg::ST_OK)) |->
		((ref_after_q == '0) && !entry_freed_q))
		else $error("error response carries entry data");

endmodule
